// File: hdl/sclx_pkg.sv
// ----------------------------------------------------------------------------
// sclx_pkg
// Shared types, codes and character tables of the streaming source lexer.
// ----------------------------------------------------------------------------
package sclx_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int DEPTH_BITS_DEF  = 16;
    localparam int MAX_KEYWORD_CHARS = 8;
    localparam int FIFO_DEPTH      = 4;
    localparam int NUM_KEYWORDS    = 19;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_KW0    = 6'd2;
    localparam logic [5:0] K_INT    = 6'd21;
    localparam logic [5:0] K_STRING = 6'd22;
    localparam logic [5:0] K_RAW    = 6'd23;
    localparam logic [5:0] K_PUNCT0 = 6'd24;
    localparam logic [5:0] K_SLASH  = 6'd38;

    localparam logic [1:0] E_NONE = 2'd0;
    localparam logic [1:0] E_RAW  = 2'd1;
    localparam logic [1:0] E_STR  = 2'd2;
    localparam logic [1:0] E_CHAR = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;
    localparam logic [7:0] CH_US    = 8'h5F;

    // raw-block intro word, packed first byte high
    localparam logic [63:0] RAW_INTRO = 64'h0000_0000_0045_5041;

    typedef enum logic [8:0] {
        M_IDLE         = 9'b000000001,
        M_COMMENT      = 9'b000000010,
        M_WORD         = 9'b000000100,
        M_INT          = 9'b000001000,
        M_STRING       = 9'b000010000,
        M_WAIT         = 9'b000100000,
        M_WAIT_COMMENT = 9'b001000000,
        M_RAW          = 9'b010000000,
        M_DONE         = 9'b100000000
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [23:0] off;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last;
    } t_tok;

    localparam logic [63:0] KW_CODE [NUM_KEYWORDS] = '{
        64'h0000_7265_7475_726E, 64'h0000_7374_7275_6374, 64'h0000_0000_7479_7065,
        64'h0000_6B65_726E_656C, 64'h0000_776F_726B_6572, 64'h6675_6E63_7469_6F6E,
        64'h0000_0000_0000_6966, 64'h0000_0000_656C_7365, 64'h0000_0077_6869_6C65,
        64'h0000_0000_0066_6F72, 64'h0000_7377_6974_6368, 64'h0000_0000_6361_7365,
        64'h0064_6566_6175_6C74, 64'h0000_0062_7265_616B, 64'h636F_6E74_696E_7565,
        64'h0064_6563_6C61_7265, 64'h0000_0000_6E65_7874, 64'h0000_0000_0072_6567,
        64'h0000_006C_6F63_616C
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd6, 4'd6, 4'd4, 4'd6, 4'd6, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3,
        4'd6, 4'd4, 4'd7, 4'd5, 4'd8, 4'd7, 4'd4, 4'd3, 4'd5
    };

    function automatic logic [5:0] word_kind(logic [63:0] wb, logic [15:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len <= 16'(MAX_KEYWORD_CHARS)) begin
            for (int i = 0; i < NUM_KEYWORDS; i++) begin
                if (len == 16'(KW_LEN[i]) && wb == KW_CODE[i]) begin
                    k = K_KW0 + 6'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= 8'h61) && (lc <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
    endfunction

    // {hit, index}
    function automatic logic [4:0] punct_idx(logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h28: r = {1'b1, 4'd0};
            8'h29: r = {1'b1, 4'd1};
            8'h7B: r = {1'b1, 4'd2};
            8'h7D: r = {1'b1, 4'd3};
            8'h5B: r = {1'b1, 4'd4};
            8'h5D: r = {1'b1, 4'd5};
            8'h2C: r = {1'b1, 4'd6};
            8'h3B: r = {1'b1, 4'd7};
            8'h3A: r = {1'b1, 4'd8};
            8'h2E: r = {1'b1, 4'd9};
            8'h3D: r = {1'b1, 4'd10};
            8'h2B: r = {1'b1, 4'd11};
            8'h2D: r = {1'b1, 4'd12};
            8'h2A: r = {1'b1, 4'd13};
            8'h2F: r = {1'b1, 4'd14};
            8'h40: r = {1'b1, 4'd15};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/sclx_out_fifo.sv
// ----------------------------------------------------------------------------
// sclx_out_fifo
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module sclx_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  sclx_pkg::t_tok i_tok0,
    input  sclx_pkg::t_tok i_tok1,
    output logic          o_room,
    output logic          o_valid,
    output sclx_pkg::t_tok o_tok,
    input  logic          i_ready
);
    import sclx_pkg::*;

    t_tok       r_mem [FIFO_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 3'd0) && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_tok   = r_mem[r_rp];
    assign o_room  = (r_cnt <= 3'd2);
    assign n_cnt   = r_cnt + {1'b0, i_push_n} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_tok0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_tok1;
        end
    end

endmodule

// File: hdl/source_code_lexer_step.sv
// ----------------------------------------------------------------------------
// source_code_lexer_step
// Streaming lexer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one byte per transfer (tuser[0] = 1 marks end of source).
//  m_axis carries tokens; tlast marks the final token caused by one input.
//  Each input byte is lexed in the cycle it is accepted and gives zero, one
//  or two tokens, written into a four-entry output queue. A token is shown
//  on m_axis from the registered queue, once the tokens ahead of it leave.
//  Throughput: one byte per cycle; s_axis_tready drops while the queue has
//  fewer than two free entries, so the queue drain of one token per cycle
//  sets the rate when bytes make tokens faster than that.
//  When m_axis is stalled the queue fills and s_axis_tready falls; nothing
//  is lost. After an error or the end item every later byte is taken and
//  dropped until reset.
//  Reset (synchronous, i_rst_n low) empties the queue and returns to line 1,
//  column 1, offset 0.
// ----------------------------------------------------------------------------
module source_code_lexer_step #(
    parameter int POS_BITS    = sclx_pkg::POS_BITS_DEF,
    parameter int OFFSET_BITS = sclx_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = sclx_pkg::DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // start_line, start_column, start_offset, text_length
    output logic [7:0]  m_axis_tuser,   // kind[5:0], error_code[7:6]
    output logic        m_axis_tlast
);
    import sclx_pkg::*;

    localparam logic [POS_BITS-1:0]    POS_MAX = {POS_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0]  DEP_MAX = {DEPTH_BITS{1'b1}};

    typedef struct packed {
        t_mode                  mode;
        logic [POS_BITS-1:0]    cur_line;
        logic [POS_BITS-1:0]    cur_col;
        logic [OFFSET_BITS-1:0] cur_off;
        logic [POS_BITS-1:0]    tok_line;
        logic [POS_BITS-1:0]    tok_col;
        logic [OFFSET_BITS-1:0] tok_off;
        logic [15:0]            tok_len;
        logic [63:0]            wb;
        logic [DEPTH_BITS-1:0]  depth;
        logic                   esc;
        logic                   slp;
        logic [POS_BITS-1:0]    sl_line;
        logic [POS_BITS-1:0]    sl_col;
        logic [OFFSET_BITS-1:0] sl_off;
    } t_st;

    localparam t_st ST_RESET = '{mode: M_IDLE, cur_line: POS_BITS'(1),
                                 cur_col: POS_BITS'(1), default: '0};

    typedef struct packed {
        t_st        s;
        t_tok       r0;
        t_tok       r1;
        logic [1:0] n;
    } t_ctx;

    function automatic logic [POS_BITS-1:0] inc_pos(logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] inc_off(logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] inc_len(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_ctx emit(t_ctx x, logic [5:0] k, logic [POS_BITS-1:0] ln,
                                  logic [POS_BITS-1:0] cl, logic [OFFSET_BITS-1:0] of,
                                  logic [15:0] len, logic [1:0] er);
        t_ctx y;
        t_tok tk;
        y = x;
        tk.kind = k;
        tk.line = 16'(ln);
        tk.col  = 16'(cl);
        tk.off  = 24'(of);
        tk.len  = len;
        tk.err  = er;
        tk.last = 1'b0;
        // a third token overwrites the second
        if (y.n == 2'd0) begin
            y.r0 = tk;
            y.n  = 2'd1;
        end else begin
            y.r1 = tk;
            y.n  = 2'd2;
        end
        return y;
    endfunction

    function automatic t_ctx adv(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = x;
        if (c == CH_NL) begin
            y.s.cur_line = inc_pos(y.s.cur_line);
            y.s.cur_col  = POS_BITS'(1);
        end else begin
            y.s.cur_col = inc_pos(y.s.cur_col);
        end
        y.s.cur_off = inc_off(y.s.cur_off);
        return y;
    endfunction

    function automatic t_ctx mark(t_ctx x);
        t_ctx y;
        y = x;
        y.s.tok_line = y.s.cur_line;
        y.s.tok_col  = y.s.cur_col;
        y.s.tok_off  = y.s.cur_off;
        y.s.tok_len  = 16'd1;
        return y;
    endfunction

    function automatic t_ctx emit_word(t_ctx x);
        return emit(x, word_kind(x.s.wb, x.s.tok_len), x.s.tok_line, x.s.tok_col,
                    x.s.tok_off, x.s.tok_len, E_NONE);
    endfunction

    function automatic t_ctx emit_slash(t_ctx x);
        return emit(x, K_SLASH, x.s.sl_line, x.s.sl_col, x.s.sl_off, 16'd1, E_NONE);
    endfunction

    function automatic t_ctx set_slash(t_ctx x);
        t_ctx y;
        y = x;
        y.s.slp     = 1'b1;
        y.s.sl_line = y.s.cur_line;
        y.s.sl_col  = y.s.cur_col;
        y.s.sl_off  = y.s.cur_off;
        return y;
    endfunction

    function automatic t_ctx idle_char(t_ctx x, logic [7:0] c);
        t_ctx       y;
        logic [4:0] p;
        logic       done;
        y    = x;
        p    = punct_idx(c);
        done = 1'b0;
        y.s.mode = M_IDLE;
        if (y.s.slp) begin
            y.s.slp = 1'b0;
            if (c == CH_SLASH) begin
                y.s.mode = M_COMMENT;
                y = adv(y, c);
                done = 1'b1;
            end else begin
                y = emit_slash(y);
            end
        end
        if (!done) begin
            if (is_space(c)) begin
                y = adv(y, c);
            end else if (c == CH_SLASH) begin
                y = set_slash(y);
                y = adv(y, c);
            end else if (is_alpha(c) || c == CH_US) begin
                y = mark(y);
                y.s.wb   = {56'd0, c};
                y.s.mode = M_WORD;
                y = adv(y, c);
            end else if (is_digit(c)) begin
                y = mark(y);
                y.s.mode = M_INT;
                y = adv(y, c);
            end else if (c == CH_DQ) begin
                y = mark(y);
                y.s.esc  = 1'b0;
                y.s.mode = M_STRING;
                y = adv(y, c);
            end else if (p[4]) begin
                y = emit(y, K_PUNCT0 + {2'b00, p[3:0]}, y.s.cur_line, y.s.cur_col,
                         y.s.cur_off, 16'd1, E_NONE);
                y = adv(y, c);
            end else begin
                y = emit(y, K_EOF, y.s.cur_line, y.s.cur_col, y.s.cur_off, 16'd0, E_CHAR);
                y.s.mode = M_DONE;
            end
        end
        return y;
    endfunction

    function automatic t_ctx wait_char(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = x;
        y.s.mode = M_WAIT;
        if (y.s.slp) begin
            if (c == CH_SLASH) begin
                y.s.slp  = 1'b0;
                y.s.mode = M_WAIT_COMMENT;
                y = adv(y, c);
            end else begin
                y = emit_word(y);
                y = idle_char(y, c);
            end
        end else if (is_space(c)) begin
            y = adv(y, c);
        end else if (c == CH_SLASH) begin
            y = set_slash(y);
            y = adv(y, c);
        end else if (c == CH_LBR) begin
            y.s.tok_line = y.s.cur_line;
            y.s.tok_col  = y.s.cur_col;
            y.s.tok_off  = inc_off(y.s.cur_off);
            y.s.tok_len  = 16'd0;
            y.s.depth    = DEPTH_BITS'(1);
            y.s.mode     = M_RAW;
            y = adv(y, c);
        end else begin
            y = emit_word(y);
            y = idle_char(y, c);
        end
        return y;
    endfunction

    function automatic t_ctx finish(t_ctx x);
        t_ctx y;
        y = x;
        case (y.s.mode)
            M_IDLE: begin
                if (y.s.slp) y = emit_slash(y);
                y = emit(y, K_EOF, y.s.cur_line, y.s.cur_col, y.s.cur_off, 16'd0, E_NONE);
            end
            M_WORD, M_WAIT, M_WAIT_COMMENT: begin
                y = emit_word(y);
                if (y.s.slp) y = emit_slash(y);
                y = emit(y, K_EOF, y.s.cur_line, y.s.cur_col, y.s.cur_off, 16'd0, E_NONE);
            end
            M_INT: begin
                y = emit(y, K_INT, y.s.tok_line, y.s.tok_col, y.s.tok_off, y.s.tok_len,
                         E_NONE);
                y = emit(y, K_EOF, y.s.cur_line, y.s.cur_col, y.s.cur_off, 16'd0, E_NONE);
            end
            M_STRING: begin
                y = emit(y, K_EOF, y.s.tok_line, y.s.tok_col, y.s.tok_off, 16'd0, E_STR);
            end
            M_RAW: begin
                y = emit(y, K_EOF, y.s.tok_line, y.s.tok_col, y.s.tok_off, 16'd0, E_RAW);
            end
            default: begin
                y = emit(y, K_EOF, y.s.cur_line, y.s.cur_col, y.s.cur_off, 16'd0, E_NONE);
            end
        endcase
        y.s.slp  = 1'b0;
        y.s.mode = M_DONE;
        return y;
    endfunction

    t_st        r_st, n_st;
    t_ctx       ctx;
    logic       in_acc;
    logic [7:0] c;
    logic       room;
    t_tok       head;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;
    assign c             = s_axis_tdata;

    always_comb begin
        ctx    = '0;
        ctx.s  = r_st;
        if (in_acc && r_st.mode != M_DONE) begin
            if (s_axis_tuser) begin
                ctx = finish(ctx);
            end else begin
                case (r_st.mode)
                    M_COMMENT: begin
                        if (c == CH_NL) ctx = idle_char(ctx, c);
                        else ctx = adv(ctx, c);
                    end
                    M_WORD: begin
                        if (is_alpha(c) || is_digit(c) || c == CH_US) begin
                            if (ctx.s.tok_len < 16'(MAX_KEYWORD_CHARS)) begin
                                ctx.s.wb = {ctx.s.wb[55:0], c};
                            end
                            ctx.s.tok_len = inc_len(ctx.s.tok_len);
                            ctx = adv(ctx, c);
                        end else if (ctx.s.tok_len == 16'd3 && ctx.s.wb == RAW_INTRO) begin
                            ctx = wait_char(ctx, c);
                        end else begin
                            ctx = emit_word(ctx);
                            ctx = idle_char(ctx, c);
                        end
                    end
                    M_INT: begin
                        if (is_digit(c)) begin
                            ctx.s.tok_len = inc_len(ctx.s.tok_len);
                            ctx = adv(ctx, c);
                        end else begin
                            ctx = emit(ctx, K_INT, ctx.s.tok_line, ctx.s.tok_col,
                                       ctx.s.tok_off, ctx.s.tok_len, E_NONE);
                            ctx = idle_char(ctx, c);
                        end
                    end
                    M_STRING: begin
                        if (ctx.s.esc) begin
                            // escaped byte moves the column even for a newline
                            ctx.s.esc     = 1'b0;
                            ctx.s.cur_col = inc_pos(ctx.s.cur_col);
                            ctx.s.cur_off = inc_off(ctx.s.cur_off);
                            ctx.s.tok_len = inc_len(ctx.s.tok_len);
                        end else if (c == CH_NL) begin
                            ctx = emit(ctx, K_EOF, ctx.s.tok_line, ctx.s.tok_col,
                                       ctx.s.tok_off, 16'd0, E_STR);
                            ctx.s.mode = M_DONE;
                        end else begin
                            if (c == CH_BSL) ctx.s.esc = 1'b1;
                            ctx.s.tok_len = inc_len(ctx.s.tok_len);
                            ctx = adv(ctx, c);
                            if (c == CH_DQ) begin
                                ctx = emit(ctx, K_STRING, ctx.s.tok_line, ctx.s.tok_col,
                                           ctx.s.tok_off, ctx.s.tok_len, E_NONE);
                                ctx.s.mode = M_IDLE;
                            end
                        end
                    end
                    M_WAIT: begin
                        ctx = wait_char(ctx, c);
                    end
                    M_WAIT_COMMENT: begin
                        if (c == CH_NL) ctx.s.mode = M_WAIT;
                        ctx = adv(ctx, c);
                    end
                    M_RAW: begin
                        if (c == CH_RBR && ctx.s.depth <= DEPTH_BITS'(1)) begin
                            ctx = emit(ctx, K_RAW, ctx.s.tok_line, ctx.s.tok_col,
                                       ctx.s.tok_off, ctx.s.tok_len, E_NONE);
                            ctx.s.mode = M_IDLE;
                        end else begin
                            if (c == CH_LBR) begin
                                ctx.s.depth = (ctx.s.depth == DEP_MAX) ? ctx.s.depth
                                                                      : ctx.s.depth + 1'b1;
                            end else if (c == CH_RBR) begin
                                ctx.s.depth = ctx.s.depth - 1'b1;
                            end
                            ctx.s.tok_len = inc_len(ctx.s.tok_len);
                        end
                        ctx = adv(ctx, c);
                    end
                    default: begin
                        ctx = idle_char(ctx, c);
                    end
                endcase
            end
        end
        ctx.r0.last = (ctx.n == 2'd1);
        ctx.r1.last = 1'b1;
        n_st = ctx.s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

    sclx_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (ctx.n),
        .i_tok0   (ctx.r0),
        .i_tok1   (ctx.r1),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .o_tok    (head),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {head.len, head.off, head.col, head.line};
    assign m_axis_tuser = {head.err, head.kind};
    assign m_axis_tlast = head.last;

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == M_DONE) |-> (ctx.n == 2'd0))
        else $error("token produced after end or error");

    a_no_push_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |-> (ctx.n == 2'd0))
        else $error("token produced without an accepted byte");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == M_DONE) |=> (r_st.mode == M_DONE))
        else $error("left finished state without reset");

    a_room_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && ctx.n == 2'd2) |=> m_axis_tvalid)
        else $error("pushed tokens not visible");

endmodule
